// ===== sv/arp_pkg.sv =====
// Shared types and constants for the MIDI note arpeggiator.
package arp_pkg;

    localparam int NOTE_W       = 7;
    localparam int DUR_W        = 16;
    localparam int COUNT_IN_W   = 13;
    localparam int OFFSET_W     = 12;
    localparam int DIVIDEND_W   = 17;

    localparam int DEF_NOTE_RANGE = 128;
    localparam int DEF_MAX_BLOCK  = 4096;

    localparam logic [DUR_W-1:0] DUR_RESET = 16'd7200;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_ADVANCE  = 2'd2
    } op_t;

    localparam logic EV_NOTE_OFF = 1'b0;
    localparam logic EV_NOTE_ON  = 1'b1;

    // Write port of the held-note memory.
    typedef struct packed {
        logic              we;
        logic [NOTE_W-1:0] addr;
        logic              data;
    } mem_wr_t;

    // Request to and response from the shared remainder unit.
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DUR_W-1:0]      divisor;
    } rem_req_t;

    typedef struct packed {
        logic             done;
        logic [DUR_W-1:0] remainder;
    } rem_rsp_t;

endpackage

// ===== sv/arp_held_mem.sv =====
// Held-note bitmap memory with one write port and one registered read port.
module arp_held_mem
    import arp_pkg::*;
#(
    parameter int NOTE_RANGE = DEF_NOTE_RANGE
)
(
    input  logic              clk,
    input  mem_wr_t           wr,
    input  logic [NOTE_W-1:0] rd_addr,
    output logic              rd_data
);

    localparam int IDX_W = (NOTE_RANGE > 1) ? $clog2(NOTE_RANGE) : 1;

    logic mem [NOTE_RANGE];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr[IDX_W-1:0]] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr[IDX_W-1:0]];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/arp_rem_unit.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
module arp_rem_unit
    import arp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rem_req_t req,
    output rem_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DUR_W-1:0]      div_reg, div_next;
    logic [DUR_W-1:0]      rem_reg, rem_next;
    logic [DUR_W:0]        trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            dvd_next  = req.dividend;
            div_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits DUR_W bits.
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = DUR_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = DUR_W'(trial);
            end
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            div_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            dvd_reg  <= dvd_next;
            div_reg  <= div_next;
            rem_reg  <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== sv/midi_note_arpeggiator_unit.sv =====
// Top level of the ascending MIDI note arpeggiator.
//
// The block keeps the set of held MIDI notes as a bitmap in a small memory and
// steps through that set in ascending note order. Note-on and note-off items
// add or remove a note and give no result; each is handled by accepting the
// item, which also issues the memory read, and then by the write-back. An
// advance item adds its sample count, clamped to MAX_BLOCK, to the elapsed
// counter. When the note duration falls inside the block, the sounding note,
// if any, is released and then the next held note, if any, is started, each
// as one result item carrying the sample offset of the event within the
// block; the last flag marks the final event of the advance. The new elapsed
// value is reduced modulo the duration by a shared remainder unit that handles
// one dividend bit per cycle. When a note starts, the same unit reduces the
// step index plus one modulo the held count, and the memory is then scanned
// one entry per cycle until the held note at that position is found. An
// advance may also wait for the output register to be taken. After reset the
// block clears the held-note memory, one entry per cycle, and accepts no item
// until every entry is cleared.
// The duration register may be written at any time the block is idle.
module midi_note_arpeggiator_unit
    import arp_pkg::*;
#(
    parameter int NOTE_RANGE = DEF_NOTE_RANGE,
    parameter int MAX_BLOCK  = DEF_MAX_BLOCK
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [DUR_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            operation,
    input  logic [NOTE_W-1:0]     note,
    input  logic [COUNT_IN_W-1:0] sample_count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  event_kind,
    output logic [NOTE_W-1:0]     note_res,
    output logic [OFFSET_W-1:0]   offset,
    output logic                  last
);

    // Wide enough to hold NOTE_RANGE itself.
    localparam int COUNT_W = $clog2(NOTE_RANGE + 1);
    localparam logic [7:0]         NOTE_LIM  = 8'(NOTE_RANGE);
    localparam logic [COUNT_W-1:0] RANGE_CNT = COUNT_W'(NOTE_RANGE);
    localparam logic [DUR_W-1:0]   BLOCK_LIM = DUR_W'(MAX_BLOCK);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_NOTE,
        S_SUM,
        S_DUE,
        S_EWAIT,
        S_OFF,
        S_STEP,
        S_SWAIT,
        S_SCAN,
        S_ON
    } state_t;

    state_t                state_reg, state_next;
    logic [DUR_W-1:0]      dur_reg, dur_next;
    logic [COUNT_W-1:0]    held_count_reg, held_count_next;
    logic [NOTE_W-1:0]     step_reg, step_next;
    logic [NOTE_W-1:0]     snd_note_reg, snd_note_next;
    logic                  snd_valid_reg, snd_valid_next;
    logic [DUR_W-1:0]      elapsed_reg, elapsed_next;
    logic [1:0]            op_reg, op_next;
    logic [NOTE_W-1:0]     note_reg, note_next;
    logic [DUR_W-1:0]      cnt_reg, cnt_next;
    logic [DUR_W-1:0]      deff_reg, deff_next;
    logic [DIVIDEND_W-1:0] sum_reg, sum_next;
    logic [OFFSET_W-1:0]   off_reg, off_next;
    logic                  due_reg, due_next;
    logic                  want_on_reg, want_on_next;
    logic [COUNT_W-1:0]    clr_reg, clr_next;
    logic [COUNT_W-1:0]    scan_reg, scan_next;
    logic [COUNT_W-1:0]    seen_reg, seen_next;
    logic [NOTE_W-1:0]     tag_reg, tag_next;
    logic                  pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_kind_reg, out_kind_next;
    logic [NOTE_W-1:0]     out_note_reg, out_note_next;
    logic [OFFSET_W-1:0]   out_off_reg, out_off_next;
    logic                  out_last_reg, out_last_next;

    mem_wr_t           mem_wr;
    logic [NOTE_W-1:0] mem_rd_addr;
    logic              mem_rd_data;
    rem_req_t          rem_req;
    rem_rsp_t          rem_rsp;

    logic              accept;
    logic              slot_free;
    logic [DUR_W-1:0]  dur_gap;
    logic [DUR_W-1:0]  off_full;

    arp_held_mem #(
        .NOTE_RANGE (NOTE_RANGE)
    ) u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    arp_rem_unit u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    // The output register can take a new item when it is empty or being emptied.
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        dur_next        = dur_reg;
        held_count_next = held_count_reg;
        step_next       = step_reg;
        snd_note_next   = snd_note_reg;
        snd_valid_next  = snd_valid_reg;
        elapsed_next    = elapsed_reg;
        op_next         = op_reg;
        note_next       = note_reg;
        cnt_next        = cnt_reg;
        deff_next       = deff_reg;
        sum_next        = sum_reg;
        off_next        = off_reg;
        due_next        = due_reg;
        want_on_next    = want_on_reg;
        clr_next        = clr_reg;
        scan_next       = scan_reg;
        seen_next       = seen_reg;
        tag_next        = tag_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_note_next   = out_note_reg;
        out_off_next    = out_off_reg;
        out_last_next   = out_last_reg;

        mem_wr.we        = 1'b0;
        mem_wr.addr      = note_reg;
        mem_wr.data      = 1'b0;
        mem_rd_addr      = note;
        rem_req.start    = 1'b0;
        rem_req.dividend = sum_reg;
        rem_req.divisor  = deff_reg;

        dur_gap  = deff_reg - elapsed_reg;
        off_full = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            dur_next = cfg_data;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = NOTE_W'(clr_reg);
                mem_wr.data = 1'b0;
                clr_next    = clr_reg + COUNT_W'(1);
                if (clr_reg == RANGE_CNT - COUNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                // The memory read for a note item is issued from the input port.
                mem_rd_addr = note;
                if (accept)
                begin
                    op_next   = operation;
                    note_next = note;
                    if ((operation == OP_NOTE_ON || operation == OP_NOTE_OFF)
                        && ({1'b0, note} < NOTE_LIM))
                    begin
                        state_next = S_NOTE;
                    end
                    else if (operation == OP_ADVANCE)
                    begin
                        if (DUR_W'(sample_count) > BLOCK_LIM)
                        begin
                            cnt_next = BLOCK_LIM;
                        end
                        else
                        begin
                            cnt_next = DUR_W'(sample_count);
                        end
                        deff_next  = (dur_reg == '0) ? DUR_W'(1) : dur_reg;
                        state_next = S_SUM;
                    end
                end
            end

            S_NOTE:
            begin
                // Read-modify-write of the held bit; the next item waits for it.
                if (op_reg == OP_NOTE_ON && !mem_rd_data)
                begin
                    mem_wr.we       = 1'b1;
                    mem_wr.data     = 1'b1;
                    held_count_next = held_count_reg + COUNT_W'(1);
                end
                else if (op_reg == OP_NOTE_OFF && mem_rd_data)
                begin
                    mem_wr.we       = 1'b1;
                    mem_wr.data     = 1'b0;
                    held_count_next = held_count_reg - COUNT_W'(1);
                end
                state_next = S_IDLE;
            end

            S_SUM:
            begin
                sum_next   = DIVIDEND_W'(elapsed_reg) + DIVIDEND_W'(cnt_reg);
                state_next = S_DUE;
            end

            S_DUE:
            begin
                due_next     = (sum_reg >= DIVIDEND_W'(deff_reg));
                want_on_next = (held_count_reg != '0);
                // Offset is the gap to the duration, clamped to the block, floored at 0.
                if (elapsed_reg >= deff_reg || cnt_reg == '0)
                begin
                    off_full = '0;
                end
                else if (dur_gap < cnt_reg)
                begin
                    off_full = dur_gap;
                end
                else
                begin
                    off_full = cnt_reg - DUR_W'(1);
                end
                off_next         = off_full[OFFSET_W-1:0];
                rem_req.start    = 1'b1;
                rem_req.dividend = sum_reg;
                rem_req.divisor  = deff_reg;
                state_next       = S_EWAIT;
            end

            S_EWAIT:
            begin
                if (rem_rsp.done)
                begin
                    elapsed_next = rem_rsp.remainder;
                    if (!due_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (snd_valid_reg)
                    begin
                        state_next = S_OFF;
                    end
                    else if (want_on_reg)
                    begin
                        state_next = S_STEP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_OFF:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = EV_NOTE_OFF;
                    out_note_next  = snd_note_reg;
                    out_off_next   = off_reg;
                    out_last_next  = !want_on_reg;
                    snd_valid_next = 1'b0;
                    state_next     = want_on_reg ? S_STEP : S_IDLE;
                end
            end

            S_STEP:
            begin
                rem_req.start    = 1'b1;
                rem_req.dividend = DIVIDEND_W'(step_reg) + DIVIDEND_W'(1);
                rem_req.divisor  = DUR_W'(held_count_reg);
                state_next       = S_SWAIT;
            end

            S_SWAIT:
            begin
                if (rem_rsp.done)
                begin
                    step_next  = NOTE_W'(rem_rsp.remainder);
                    scan_next  = '0;
                    seen_next  = '0;
                    pend_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // One read is issued per cycle; data returns in the next cycle with its tag.
                mem_rd_addr = NOTE_W'(scan_reg);
                if (pend_reg && mem_rd_data && (seen_reg == COUNT_W'(step_reg)))
                begin
                    snd_note_next  = tag_reg;
                    snd_valid_next = 1'b1;
                    state_next     = S_ON;
                end
                else
                begin
                    if (pend_reg && mem_rd_data)
                    begin
                        seen_next = seen_reg + COUNT_W'(1);
                    end
                    if (scan_reg < RANGE_CNT)
                    begin
                        tag_next  = NOTE_W'(scan_reg);
                        pend_next = 1'b1;
                        scan_next = scan_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (!pend_reg)
                        begin
                            // No held note at that position: fall back to note zero.
                            snd_note_next  = '0;
                            snd_valid_next = 1'b1;
                            state_next     = S_ON;
                        end
                    end
                end
            end

            S_ON:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = EV_NOTE_ON;
                    out_note_next  = snd_note_reg;
                    out_off_next   = off_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            dur_reg        <= DUR_RESET;
            held_count_reg <= '0;
            step_reg       <= '0;
            snd_note_reg   <= '0;
            snd_valid_reg  <= 1'b0;
            elapsed_reg    <= '0;
            op_reg         <= '0;
            note_reg       <= '0;
            cnt_reg        <= '0;
            deff_reg       <= DUR_W'(1);
            sum_reg        <= '0;
            off_reg        <= '0;
            due_reg        <= 1'b0;
            want_on_reg    <= 1'b0;
            clr_reg        <= '0;
            scan_reg       <= '0;
            seen_reg       <= '0;
            tag_reg        <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= 1'b0;
            out_note_reg   <= '0;
            out_off_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            dur_reg        <= dur_next;
            held_count_reg <= held_count_next;
            step_reg       <= step_next;
            snd_note_reg   <= snd_note_next;
            snd_valid_reg  <= snd_valid_next;
            elapsed_reg    <= elapsed_next;
            op_reg         <= op_next;
            note_reg       <= note_next;
            cnt_reg        <= cnt_next;
            deff_reg       <= deff_next;
            sum_reg        <= sum_next;
            off_reg        <= off_next;
            due_reg        <= due_next;
            want_on_reg    <= want_on_next;
            clr_reg        <= clr_next;
            scan_reg       <= scan_next;
            seen_reg       <= seen_next;
            tag_reg        <= tag_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_note_reg   <= out_note_next;
            out_off_reg    <= out_off_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign note_res   = out_note_reg;
    assign offset     = out_off_reg;
    assign last       = out_last_reg;

endmodule
